// ===== hdl/disparity_to_point_reprojection_unit_assert.svh =====
// Concurrent assertion helpers; both sample on clk and are off while rst_n is low.
`ifndef DISPARITY_TO_POINT_REPROJECTION_UNIT_ASSERT_SVH
`define DISPARITY_TO_POINT_REPROJECTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DPR_ASSERT_NOW(label, ante, cons, msg)
`define DPR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/dpr_pkg.sv =====
`timescale 1ns / 1ps
package dpr_pkg;

  localparam int COORD_BITS     = 12;
  localparam int DISP_FRAC_BITS = 4;
  localparam int CAL_FRAC_BITS  = 4;

  localparam int CX_W    = 16;
  localparam int CY_W    = 16;
  localparam int FX_W    = 18;
  localparam int FY_W    = 18;
  localparam int BASE_W  = 20;
  localparam int DISP_W  = 16;
  localparam int COLOR_W = 8;
  localparam int POINT_W = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = CFG_IDX_W'(4);

  localparam logic [FX_W-1:0] FOCAL_RESET = FX_W'(16);

  // disparity of exactly -1 pixel marks an invalid pixel
  localparam logic [DISP_W-1:0] DISP_INVALID = DISP_W'(-(1 << DISP_FRAC_BITS));

  localparam int IN_FIELDS_W  = 2 * COORD_BITS + DISP_W + 3 * COLOR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * POINT_W + 3 * COLOR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int IN_ROW_LSB   = COORD_BITS;
  localparam int IN_DISP_LSB  = 2 * COORD_BITS;
  localparam int IN_BLUE_LSB  = IN_DISP_LSB + DISP_W;
  localparam int IN_GREEN_LSB = IN_BLUE_LSB + COLOR_W;
  localparam int IN_RED_LSB   = IN_GREEN_LSB + COLOR_W;

  // magnitude of u and v: 16*coord against a 16-bit principal point
  localparam int UMAG_W = (COORD_BITS + CAL_FRAC_BITS > CX_W) ?
                          (COORD_BITS + CAL_FRAC_BITS) : CX_W;
  localparam int DIV_W  = DISP_W + CAL_FRAC_BITS;
  localparam int DVY_W  = DIV_W + FY_W;

  localparam int PX_W = UMAG_W + BASE_W;
  localparam int PV_W = UMAG_W + FX_W;
  localparam int PY_W = PV_W + BASE_W;
  localparam int PZ_W = FX_W + BASE_W;

  localparam int NX_W = PX_W + DISP_FRAC_BITS;
  localparam int NY_W = PY_W + DISP_FRAC_BITS;
  localparam int NZ_W = PZ_W + DISP_FRAC_BITS;

  localparam int Q_W  = POINT_W;
  localparam int HX_W = NX_W - Q_W;
  localparam int HY_W = NY_W - Q_W;
  localparam int HZ_W = NZ_W - Q_W;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               x_neg;
    logic               y_neg;
    logic               z_neg;
  } side_t;

  // clamp a quotient magnitude with sign to the signed 32-bit range
  function automatic logic [POINT_W-1:0] sat_point(input logic neg, input logic ovf,
                                                   input logic [POINT_W-1:0] q);
    logic [POINT_W-1:0] res;
    if (!neg) begin
      res = (ovf || q[POINT_W-1]) ? {1'b0, {(POINT_W-1){1'b1}}} : q;
    end else if (ovf || (q[POINT_W-1] && (q[POINT_W-2:0] != '0))) begin
      res = {1'b1, {(POINT_W-1){1'b0}}};
    end else begin
      res = ~q + 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== hdl/disparity_to_point_reprojection_unit.sv =====
// Pipeline: 4 front stages, 32 restoring-division stages at one quotient bit each and
// one output register. Throughput: one word per cycle while the skid word is empty;
// a two-word output stage absorbs an output stall before in_tready drops.
// Words with zero or invalid disparity are dropped at the input stage.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
`include "disparity_to_point_reprojection_unit_assert.svh"
module disparity_to_point_reprojection_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dpr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // pixel_column, pixel_row, disparity, blue, green, red
  input  logic [dpr_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // point_x, point_y, point_z, out_red, out_green, out_blue
  output logic [dpr_pkg::OUT_DATA_W-1:0]       out_tdata
);

  localparam int Q_W    = dpr_pkg::Q_W;
  localparam int UMAG_W = dpr_pkg::UMAG_W;
  localparam int DIV_W  = dpr_pkg::DIV_W;
  localparam int DVY_W  = dpr_pkg::DVY_W;

  // ---------------- configuration registers ----------------
  logic [dpr_pkg::CX_W-1:0]   center_x_r;
  logic [dpr_pkg::CY_W-1:0]   center_y_r;
  logic [dpr_pkg::FX_W-1:0]   focal_x_r;
  logic [dpr_pkg::FY_W-1:0]   focal_y_r;
  logic [dpr_pkg::BASE_W-1:0] baseline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      focal_x_r  <= dpr_pkg::FOCAL_RESET;
      focal_y_r  <= dpr_pkg::FOCAL_RESET;
      baseline_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dpr_pkg::CFG_CENTER_X: center_x_r <= cfg_data[dpr_pkg::CX_W-1:0];
        dpr_pkg::CFG_CENTER_Y: center_y_r <= cfg_data[dpr_pkg::CY_W-1:0];
        dpr_pkg::CFG_FOCAL_X:  focal_x_r  <= cfg_data[dpr_pkg::FX_W-1:0];
        dpr_pkg::CFG_FOCAL_Y:  focal_y_r  <= cfg_data[dpr_pkg::FY_W-1:0];
        dpr_pkg::CFG_BASELINE: baseline_r <= cfg_data[dpr_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero focal_y reads as the smallest legal value
  logic [dpr_pkg::FY_W-1:0] focal_y_eff;
  assign focal_y_eff = (focal_y_r == '0) ? dpr_pkg::FY_W'(1) : focal_y_r;

  // ---------------- output stage and pipeline enable ----------------
  logic                          out_vld_r;
  logic [dpr_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                          skid_vld_r;
  logic [dpr_pkg::OUT_DATA_W-1:0] skid_data_r;
  logic                          en;
  logic                          out_free;

  // whole pipe moves unless the skid word is occupied
  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign out_free  = !out_vld_r || out_tready;

  // ---------------- stage 1: field split, u, v, |d| ----------------
  logic [dpr_pkg::COORD_BITS-1:0] in_col, in_row;
  logic [dpr_pkg::DISP_W-1:0]     in_disp;
  logic                           in_keep;
  logic [UMAG_W:0]                u_diff, v_diff;
  logic                           d_neg, u_pos, v_pos;

  assign in_col  = in_tdata[dpr_pkg::COORD_BITS-1:0];
  assign in_row  = in_tdata[dpr_pkg::IN_ROW_LSB +: dpr_pkg::COORD_BITS];
  assign in_disp = in_tdata[dpr_pkg::IN_DISP_LSB +: dpr_pkg::DISP_W];
  assign in_keep = (in_disp != '0) && (in_disp != dpr_pkg::DISP_INVALID);

  assign u_diff = ((UMAG_W+1)'(in_col) << dpr_pkg::CAL_FRAC_BITS) - (UMAG_W+1)'(center_x_r);
  assign v_diff = ((UMAG_W+1)'(in_row) << dpr_pkg::CAL_FRAC_BITS) - (UMAG_W+1)'(center_y_r);
  assign d_neg  = in_disp[dpr_pkg::DISP_W-1];
  assign u_pos  = !u_diff[UMAG_W] && (u_diff != '0);
  assign v_pos  = !v_diff[UMAG_W] && (v_diff != '0);

  logic                       s1_vld_r;
  logic [UMAG_W-1:0]          s1_umag_r, s1_vmag_r;
  logic [dpr_pkg::DISP_W-1:0] s1_dmag_r;
  dpr_pkg::side_t             s1_side_r;
  dpr_pkg::side_t             s1_side_nxt;

  always_comb begin
    s1_side_nxt.red   = in_tdata[dpr_pkg::IN_RED_LSB +: dpr_pkg::COLOR_W];
    s1_side_nxt.green = in_tdata[dpr_pkg::IN_GREEN_LSB +: dpr_pkg::COLOR_W];
    s1_side_nxt.blue  = in_tdata[dpr_pkg::IN_BLUE_LSB +: dpr_pkg::COLOR_W];
    s1_side_nxt.x_neg = u_pos ^ d_neg;
    s1_side_nxt.y_neg = v_pos ^ d_neg;
    s1_side_nxt.z_neg = d_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_tvalid && in_keep;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_umag_r <= UMAG_W'(u_diff[UMAG_W] ? (~u_diff + 1'b1) : u_diff);
      s1_vmag_r <= UMAG_W'(v_diff[UMAG_W] ? (~v_diff + 1'b1) : v_diff);
      s1_dmag_r <= d_neg ? (~in_disp + 1'b1) : in_disp;
      s1_side_r <= s1_side_nxt;
    end
  end

  // ---------------- stage 2: first products ----------------
  logic                     s2_vld_r;
  logic [dpr_pkg::PX_W-1:0] s2_px_r;
  logic [dpr_pkg::PV_W-1:0] s2_pv_r;
  logic [dpr_pkg::PZ_W-1:0] s2_pz_r;
  logic [DIV_W-1:0]         s2_dv_r;
  logic [DVY_W-1:0]         s2_dvy_r;
  dpr_pkg::side_t           s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_px_r   <= dpr_pkg::PX_W'(s1_umag_r) * dpr_pkg::PX_W'(baseline_r);
      s2_pv_r   <= dpr_pkg::PV_W'(s1_vmag_r) * dpr_pkg::PV_W'(focal_x_r);
      s2_pz_r   <= dpr_pkg::PZ_W'(focal_x_r) * dpr_pkg::PZ_W'(baseline_r);
      s2_dv_r   <= DIV_W'(s1_dmag_r) << dpr_pkg::CAL_FRAC_BITS;
      s2_dvy_r  <= (DVY_W'(s1_dmag_r) * DVY_W'(focal_y_eff)) << dpr_pkg::CAL_FRAC_BITS;
      s2_side_r <= s1_side_r;
    end
  end

  // ---------------- stage 3: |v|*fx*B ----------------
  logic                     s3_vld_r;
  logic [dpr_pkg::PX_W-1:0] s3_px_r;
  logic [dpr_pkg::PY_W-1:0] s3_py_r;
  logic [dpr_pkg::PZ_W-1:0] s3_pz_r;
  logic [DIV_W-1:0]         s3_dv_r;
  logic [DVY_W-1:0]         s3_dvy_r;
  dpr_pkg::side_t           s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_px_r   <= s2_px_r;
      s3_py_r   <= dpr_pkg::PY_W'(s2_pv_r) * dpr_pkg::PY_W'(baseline_r);
      s3_pz_r   <= s2_pz_r;
      s3_dv_r   <= s2_dv_r;
      s3_dvy_r  <= s2_dvy_r;
      s3_side_r <= s2_side_r;
    end
  end

  // ---------------- stage 4: dividend, overflow check, initial remainder ----------------
  // quotient >= 2^32 exactly when the dividend's upper part is not below the divisor
  logic [dpr_pkg::NX_W-1:0] x_num;
  logic [dpr_pkg::NY_W-1:0] y_num;
  logic [dpr_pkg::NZ_W-1:0] z_num;
  logic [dpr_pkg::HX_W-1:0] x_hi;
  logic [dpr_pkg::HY_W-1:0] y_hi;
  logic [dpr_pkg::HZ_W-1:0] z_hi;
  logic [2:0]               ovf_nxt;

  assign x_num = dpr_pkg::NX_W'(s3_px_r) << dpr_pkg::DISP_FRAC_BITS;
  assign y_num = dpr_pkg::NY_W'(s3_py_r) << dpr_pkg::DISP_FRAC_BITS;
  assign z_num = dpr_pkg::NZ_W'(s3_pz_r) << dpr_pkg::DISP_FRAC_BITS;
  assign x_hi  = x_num[dpr_pkg::NX_W-1:Q_W];
  assign y_hi  = y_num[dpr_pkg::NY_W-1:Q_W];
  assign z_hi  = z_num[dpr_pkg::NZ_W-1:Q_W];

  assign ovf_nxt[0] = {{DIV_W{1'b0}}, x_hi} >= {{dpr_pkg::HX_W{1'b0}}, s3_dv_r};
  assign ovf_nxt[1] = {{DVY_W{1'b0}}, y_hi} >= {{dpr_pkg::HY_W{1'b0}}, s3_dvy_r};
  assign ovf_nxt[2] = {{DIV_W{1'b0}}, z_hi} >= {{dpr_pkg::HZ_W{1'b0}}, s3_dv_r};

  // division pipe: index 0 is stage 4, index Q_W holds finished quotients
  logic           dvld_r [0:Q_W];
  dpr_pkg::side_t dside_r[0:Q_W];
  logic [2:0]     ovf_r  [0:Q_W];
  logic [Q_W-1:0] xw_r   [0:Q_W];
  logic [Q_W-1:0] yw_r   [0:Q_W];
  logic [Q_W-1:0] zw_r   [0:Q_W];
  logic [DIV_W-1:0] xrem_r[0:Q_W-1];
  logic [DVY_W-1:0] yrem_r[0:Q_W-1];
  logic [DIV_W-1:0] zrem_r[0:Q_W-1];
  logic [DIV_W-1:0] xdv_r [0:Q_W-1];
  logic [DVY_W-1:0] ydv_r [0:Q_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) dvld_r[0] <= 1'b0;
    else if (en) dvld_r[0] <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0] <= s3_side_r;
      ovf_r[0]   <= ovf_nxt;
      xw_r[0]    <= x_num[Q_W-1:0];
      yw_r[0]    <= y_num[Q_W-1:0];
      zw_r[0]    <= z_num[Q_W-1:0];
      xrem_r[0]  <= ovf_nxt[0] ? '0 : DIV_W'(x_hi);
      yrem_r[0]  <= ovf_nxt[1] ? '0 : DVY_W'(y_hi);
      zrem_r[0]  <= ovf_nxt[2] ? '0 : DIV_W'(z_hi);
      xdv_r[0]   <= s3_dv_r;
      ydv_r[0]   <= s3_dvy_r;
    end
  end

  // one restoring step per stage; the word shifts dividend bits out and quotient bits in
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [DIV_W:0] xt, zt;
    logic [DVY_W:0] yt;
    logic           xge, yge, zge;

    assign xt  = {xrem_r[k], xw_r[k][Q_W-1]};
    assign yt  = {yrem_r[k], yw_r[k][Q_W-1]};
    assign zt  = {zrem_r[k], zw_r[k][Q_W-1]};
    assign xge = xt >= {1'b0, xdv_r[k]};
    assign yge = yt >= {1'b0, ydv_r[k]};
    assign zge = zt >= {1'b0, xdv_r[k]};  // z shares the x divisor

    always_ff @(posedge clk) begin
      if (!rst_n) dvld_r[k+1] <= 1'b0;
      else if (en) dvld_r[k+1] <= dvld_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside_r[k+1] <= dside_r[k];
        ovf_r[k+1]   <= ovf_r[k];
        xw_r[k+1]    <= {xw_r[k][Q_W-2:0], xge};
        yw_r[k+1]    <= {yw_r[k][Q_W-2:0], yge};
        zw_r[k+1]    <= {zw_r[k][Q_W-2:0], zge};
      end
    end

    if (k < Q_W - 1) begin : g_carry
      logic [DIV_W-1:0] xrem_nxt, zrem_nxt;
      logic [DVY_W-1:0] yrem_nxt;

      assign xrem_nxt = xge ? DIV_W'(xt - {1'b0, xdv_r[k]}) : xt[DIV_W-1:0];
      assign yrem_nxt = yge ? DVY_W'(yt - {1'b0, ydv_r[k]}) : yt[DVY_W-1:0];
      assign zrem_nxt = zge ? DIV_W'(zt - {1'b0, xdv_r[k]}) : zt[DIV_W-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          xrem_r[k+1] <= xrem_nxt;
          yrem_r[k+1] <= yrem_nxt;
          zrem_r[k+1] <= zrem_nxt;
          xdv_r[k+1]  <= xdv_r[k];
          ydv_r[k+1]  <= ydv_r[k];
        end
      end
    end
  end

  // ---------------- saturation and output ----------------
  dpr_pkg::side_t                 last_side;
  logic [dpr_pkg::POINT_W-1:0]    pt_x, pt_y, pt_z;
  logic [dpr_pkg::OUT_DATA_W-1:0] res;
  logic                           arrive;

  assign last_side = dside_r[Q_W];
  assign pt_x = dpr_pkg::sat_point(last_side.x_neg, ovf_r[Q_W][0], xw_r[Q_W]);
  assign pt_y = dpr_pkg::sat_point(last_side.y_neg, ovf_r[Q_W][1], yw_r[Q_W]);
  assign pt_z = dpr_pkg::sat_point(last_side.z_neg, ovf_r[Q_W][2], zw_r[Q_W]);
  assign res  = dpr_pkg::OUT_DATA_W'({last_side.blue, last_side.green, last_side.red,
                                      pt_z, pt_y, pt_x});
  assign arrive = dvld_r[Q_W] && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= arrive;
      end
    end else if (arrive) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) out_data_r <= skid_vld_r ? skid_data_r : res;
    if (out_vld_r && !out_tready && arrive) skid_data_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  `DPR_ASSERT_NOW(a_skid_behind_out, skid_vld_r, out_vld_r, "skid word held with output empty")
  `DPR_ASSERT_NEXT(a_drop_bad_disp, en && !in_keep, !s1_vld_r, "dropped word entered pipe")
  `DPR_ASSERT_NEXT(a_skid_drains, skid_vld_r && out_tready, !skid_vld_r, "skid word not moved")
  `DPR_ASSERT_NEXT(a_skid_on_stall, !skid_vld_r && out_free, !skid_vld_r, "skid without stall")

endmodule
